>>> hw/rtl/piq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piq_pkg
// shared types and constants of the priority interrupt queue
// ----------------------------------------------------------------------------
package piq_pkg;

    localparam int NUM_SOURCES_DEF = 32;

    localparam int OP_W   = 2;
    localparam int SRC_W  = 5;
    localparam int PRIO_W = 8;
    localparam int LVL_W  = 3;
    localparam int VEC_W  = 8;

    localparam logic [OP_W-1:0] OP_RAISE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOWER  = 2'd1;
    localparam logic [OP_W-1:0] OP_VECTOR = 2'd2;

    // one list entry as kept in the order memory
    typedef struct packed {
        logic [SRC_W-1:0]  src;
        logic [PRIO_W-1:0] prio;
        logic [LVL_W-1:0]  lvl;
        logic [VEC_W-1:0]  vec;
    } entry_t;

    typedef enum logic [1:0] {
        RD_BELOW = 2'd0,
        RD_AT    = 2'd1,
        RD_HEAD  = 2'd2
    } rd_mode_t;

    typedef struct packed {
        logic     load;
        logic     check;
        logic     raise_init;
        logic     lower_init;
        logic     rd_en;
        rd_mode_t rd_mode;
        logic     shift_up;
        logic     wr_new;
        logic     lower_step;
        logic     lower_finish;
        logic     head_update;
        logic     emit;
    } piq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            raise_ok;
        logic            lower_ok;
        logic            idx_zero;
        logic            idx_at_count;
        logic            prio_gt;
        logic            out_free;
    } piq_status_t;

endpackage : piq_pkg
`default_nettype wire

>>> hw/rtl/priority_interrupt_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_interrupt_queue_core
// ordered queue of pending interrupt sources with head level and vector read
// ----------------------------------------------------------------------------
// One item is in work at a time. A vector read, an ignored raise or lower and
// the unused op go straight from the check to the result. A raise moves each
// pending entry with a strictly larger priority number up one place, walking
// down from the tail; when every entry moves, the new entry becomes the head.
// A lower walks all n entries of the list, n being its length before the lower.
// The order memory serves one access per step: each visited entry costs a read
// step and a compare/move step, plus a read of the head entry at the end. A
// result waits in an output register; the next item is taken in the cycle
// after the current one has been handed to that register, and the handover
// stalls while that register still holds an unaccepted result. No clearing
// pass is needed.
// ----------------------------------------------------------------------------
module priority_interrupt_queue_core #(
    parameter int NUM_SOURCES = piq_pkg::NUM_SOURCES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [piq_pkg::OP_W-1:0]     op,
    input  wire  [piq_pkg::SRC_W-1:0]    source,
    input  wire  [piq_pkg::PRIO_W-1:0]   priority_req,
    input  wire  [piq_pkg::LVL_W-1:0]    level,
    input  wire  [piq_pkg::VEC_W-1:0]    vector,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [piq_pkg::LVL_W-1:0]    active_level,
    output logic [piq_pkg::VEC_W-1:0]    ack_vector,
    output logic                         no_change
);
    import piq_pkg::*;

    piq_cmd_t    cmd;
    piq_status_t status;

    piq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    piq_datapath #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .source       (source),
        .priority_req (priority_req),
        .level        (level),
        .vector       (vector),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .active_level (active_level),
        .ack_vector   (ack_vector),
        .no_change    (no_change)
    );

endmodule : priority_interrupt_queue_core
`default_nettype wire

>>> hw/rtl/piq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piq_datapath
// item latch, order memory, pending flags, scan index, head and result registers
// ----------------------------------------------------------------------------
module piq_datapath #(
    parameter int NUM_SOURCES = piq_pkg::NUM_SOURCES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  piq_pkg::piq_cmd_t      cmd,
    output piq_pkg::piq_status_t         status,
    input  wire  [piq_pkg::OP_W-1:0]     op,
    input  wire  [piq_pkg::SRC_W-1:0]    source,
    input  wire  [piq_pkg::PRIO_W-1:0]   priority_req,
    input  wire  [piq_pkg::LVL_W-1:0]    level,
    input  wire  [piq_pkg::VEC_W-1:0]    vector,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [piq_pkg::LVL_W-1:0]    active_level,
    output logic [piq_pkg::VEC_W-1:0]    ack_vector,
    output logic                         no_change
);
    import piq_pkg::*;

    localparam int IDX_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CNT_W     = $clog2(NUM_SOURCES + 1);
    localparam int SRC_EXT_W = ((SRC_W > IDX_W) ? SRC_W : IDX_W) + 1;

    entry_t mem [NUM_SOURCES];
    entry_t rd_data_reg;

    logic [OP_W-1:0]     op_reg;
    entry_t              item_reg;
    logic [NUM_SOURCES-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic                nochg_reg;
    logic [LVL_W-1:0]    head_lvl_reg, head_lvl_next;
    logic [VEC_W-1:0]    head_vec_reg, head_vec_next;
    logic                out_valid_reg;
    logic [LVL_W-1:0]    active_level_reg;
    logic [VEC_W-1:0]    ack_vector_reg;
    logic                no_change_reg;

    logic [SRC_EXT_W-1:0] src_ext;
    logic [IDX_W-1:0]     src_idx;
    logic                 in_range;
    logic                 is_pending;
    logic [CNT_W-1:0]     idx_m1;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic [IDX_W-1:0]     rd_addr;

    assign src_ext    = SRC_EXT_W'(item_reg.src);
    assign src_idx    = src_ext[IDX_W-1:0];
    assign in_range   = src_ext < SRC_EXT_W'(NUM_SOURCES);
    assign is_pending = in_range ? pending_reg[src_idx] : 1'b0;
    assign idx_m1     = idx_reg - CNT_W'(1);

    always_comb
    begin
        status.op           = op_reg;
        status.raise_ok     = in_range && !is_pending && (count_reg < CNT_W'(NUM_SOURCES));
        status.lower_ok     = is_pending;
        status.idx_zero     = (idx_reg == '0);
        status.idx_at_count = (idx_reg == count_reg);
        status.prio_gt      = (rd_data_reg.prio > item_reg.prio);
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        unique case (cmd.rd_mode)
            RD_BELOW: rd_addr = idx_m1[IDX_W-1:0];
            RD_AT:    rd_addr = idx_reg[IDX_W-1:0];
            RD_HEAD:  rd_addr = '0;
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        if (cmd.wr_new)
        begin
            wr_en   = 1'b1;
            wr_data = item_reg;
        end
        else if (cmd.shift_up)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.lower_step && found_reg)
        begin
            // close the gap left by the removed entry
            wr_en   = 1'b1;
            wr_addr = idx_m1[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            item_reg.src  <= source;
            item_reg.prio <= priority_req;
            item_reg.lvl  <= level;
            item_reg.vec  <= vector;
        end
        if (cmd.check)
        begin
            if (op_reg == OP_RAISE)
            begin
                nochg_reg <= !status.raise_ok;
            end
            else if (op_reg == OP_LOWER)
            begin
                nochg_reg <= !status.lower_ok;
            end
            else
            begin
                nochg_reg <= 1'b0;
            end
        end
        if (cmd.emit)
        begin
            active_level_reg <= head_lvl_reg;
            ack_vector_reg   <= (op_reg == OP_VECTOR) ? head_vec_reg : '0;
            no_change_reg    <= nochg_reg;
        end
    end

    always_comb
    begin
        pending_next  = pending_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        head_lvl_next = head_lvl_reg;
        head_vec_next = head_vec_reg;
        if (cmd.raise_init)
        begin
            idx_next = count_reg;
        end
        if (cmd.lower_init)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        if (cmd.shift_up)
        begin
            idx_next = idx_m1;
        end
        if (cmd.wr_new)
        begin
            pending_next[src_idx] = 1'b1;
            count_next            = count_reg + CNT_W'(1);
        end
        if (cmd.lower_step)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (rd_data_reg.src == item_reg.src)
            begin
                found_next = 1'b1;
            end
        end
        if (cmd.lower_finish)
        begin
            pending_next[src_idx] = 1'b0;
            count_next            = count_reg - CNT_W'(1);
        end
        if (cmd.head_update)
        begin
            if (count_reg != '0)
            begin
                head_lvl_next = rd_data_reg.lvl;
                head_vec_next = rd_data_reg.vec;
            end
            else
            begin
                head_lvl_next = '0;
                head_vec_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            head_lvl_reg  <= '0;
            head_vec_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            head_lvl_reg <= head_lvl_next;
            head_vec_reg <= head_vec_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign active_level = active_level_reg;
    assign ack_vector   = ack_vector_reg;
    assign no_change    = no_change_reg;

endmodule : piq_datapath
`default_nettype wire

>>> hw/rtl/piq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piq_ctrl
// sequencer for list insertion, removal and head refresh
// ----------------------------------------------------------------------------
module piq_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire piq_pkg::piq_status_t status,
    output piq_pkg::piq_cmd_t     cmd
);
    import piq_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_R_RD  = 9'b000000100,
        ST_R_EV  = 9'b000001000,
        ST_L_RD  = 9'b000010000,
        ST_L_EV  = 9'b000100000,
        ST_H_RD  = 9'b001000000,
        ST_H_EV  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_mode = RD_AT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.op == OP_RAISE && status.raise_ok)
                begin
                    cmd.raise_init = 1'b1;
                    state_next     = ST_R_RD;
                end
                else if (status.op == OP_LOWER && status.lower_ok)
                begin
                    cmd.lower_init = 1'b1;
                    state_next     = ST_L_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_R_RD:
            begin
                // walk down from the tail, moving strictly larger priorities up
                if (status.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_H_RD;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = RD_BELOW;
                    state_next  = ST_R_EV;
                end
            end
            ST_R_EV:
            begin
                if (status.prio_gt)
                begin
                    cmd.shift_up = 1'b1;
                    state_next   = ST_R_RD;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_H_RD;
                end
            end
            ST_L_RD:
            begin
                if (status.idx_at_count)
                begin
                    cmd.lower_finish = 1'b1;
                    state_next       = ST_H_RD;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = RD_AT;
                    state_next  = ST_L_EV;
                end
            end
            ST_L_EV:
            begin
                cmd.lower_step = 1'b1;
                state_next     = ST_L_RD;
            end
            ST_H_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_HEAD;
                state_next  = ST_H_EV;
            end
            ST_H_EV:
            begin
                cmd.head_update = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : piq_ctrl
`default_nettype wire
